### rtl/elitist_population_replacement_assert.svh
// assertion macros used by the checker file epr_checker.sv
`ifndef ELITIST_POPULATION_REPLACEMENT_ASSERT_SVH
`define ELITIST_POPULATION_REPLACEMENT_ASSERT_SVH

// same-cycle implication, clocked on clk, quiet while rst_n is low
`define EPR_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("epr assertion failed");

// next-cycle implication, clocked on clk, quiet while rst_n is low
`define EPR_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("epr assertion failed");

`endif

### rtl/epr_pkg.sv
// ----------------------------------------------------------------------------
// epr_pkg
// Shared types and constants of the elitist replacement block.
// ----------------------------------------------------------------------------
package epr_pkg;

  // table geometry
  localparam int MAX_POPULATION = 256;
  localparam int IDX_W          = $clog2(MAX_POPULATION);
  localparam int CNT_W          = $clog2(MAX_POPULATION + 1);
  localparam int SWP_W          = $clog2(MAX_POPULATION + 2);

  // field widths
  localparam int FIT_W     = 30;
  localparam int TAG_W     = 16;
  localparam int SLOT_W    = 8;
  localparam int CNT_OUT_W = 9;
  localparam int POP_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 9;

  localparam logic [FIT_W-1:0] FITNESS_CEIL = 30'd999999998;

  // register indices
  localparam logic [CFG_IDX_W-1:0] CFG_POP_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_MODE = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD_CUR = 2'd0,
    CMD_LOAD_OFF = 2'd1,
    CMD_RUN      = 2'd2,
    CMD_READ     = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [FIT_W-1:0] fitness;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // write request into one table
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tab_wr_t;

endpackage

### rtl/epr_ifs.sv
// ----------------------------------------------------------------------------
// epr_ifs
// Valid/ready channels carrying command words in and result words out.
// ----------------------------------------------------------------------------
interface epr_in_if import epr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [SLOT_W-1:0] slot;
  logic [FIT_W-1:0]  fitness;
  logic [TAG_W-1:0]  tag;

  modport source (output valid, cmd, slot, fitness, tag, input ready);
  modport sink   (input valid, cmd, slot, fitness, tag, output ready);
endinterface

interface epr_out_if import epr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FIT_W-1:0]     out_fitness;
  logic [TAG_W-1:0]     out_tag;
  logic [CNT_OUT_W-1:0] swap_count;

  modport source (output valid, out_fitness, out_tag, swap_count, input ready);
  modport sink   (input valid, out_fitness, out_tag, swap_count, output ready);
endinterface

### rtl/epr_table.sv
// ----------------------------------------------------------------------------
// epr_table
// One population table: single write port, single read port, registered read.
// ----------------------------------------------------------------------------
module epr_table import epr_pkg::*; (
  input  logic             clk,
  input  tab_wr_t          wr,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [MAX_POPULATION];
  entry_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read port, registered, updated only while re is high
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/elitist_population_replacement.sv
// ----------------------------------------------------------------------------
// elitist_population_replacement
// Current and offspring tables with load, read and elitist replacement run.
// ----------------------------------------------------------------------------
// Load and read words are taken one per cycle while no run is active and the
// result side keeps up; every word gives one result word, a read result in
// the cycle after the command. A run holds off the input while it sweeps both
// tables through their single read ports: each pass reads the n scanned slots
// through the registered read, then compares and exchanges, so a run making
// s exchanges makes s + 1 passes. Table contents are undefined until loaded;
// there is no clearing pass after reset.
module elitist_population_replacement import epr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  epr_in_if.sink               in_ch,
  epr_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  state_t               state_r;
  logic [POP_W-1:0]     pop_r;
  logic                 half_r;
  logic [CNT_W-1:0]     m_r;
  logic [CNT_W-1:0]     issue_r;
  logic                 rvalid_r;
  logic [CNT_W-1:0]     ridx_r;
  logic                 found_r;
  logic [IDX_W-1:0]     wi_r;
  logic [FIT_W-1:0]     wv_r;
  logic [TAG_W-1:0]     wtag_r;
  logic [IDX_W-1:0]     bi_r;
  logic [FIT_W-1:0]     bv_r;
  logic [TAG_W-1:0]     btag_r;
  logic [SWP_W-1:0]     swaps_r;
  logic                 out_valid_r;
  logic                 out_rd_r;
  logic [CNT_OUT_W-1:0] out_swaps_r;

  logic                 accept;
  cmd_t                 cmd;
  logic                 in_range;
  logic [FIT_W-1:0]     fit_sat;
  logic [CNT_W-1:0]     m_full;
  logic [CNT_W-1:0]     m_scan;
  logic                 issue_now;
  logic                 do_swap;
  logic                 out_set;
  logic                 rd_re;
  logic [IDX_W-1:0]     rd_addr;
  tab_wr_t              cur_wr;
  tab_wr_t              off_wr;
  entry_t               cur_q;
  entry_t               off_q;

  // input decode
  assign cmd      = cmd_t'(in_ch.cmd);
  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept   = in_ch.valid && in_ch.ready;
  assign in_range = 32'(in_ch.slot) < 32'(MAX_POPULATION);
  assign fit_sat  = (in_ch.fitness > FITNESS_CEIL) ? FITNESS_CEIL : in_ch.fitness;

  // number of scanned slots
  assign m_full = (32'(pop_r) > 32'(MAX_POPULATION)) ? CNT_W'(MAX_POPULATION)
                                                      : CNT_W'(pop_r);
  assign m_scan = half_r ? (m_full >> 1) : m_full;

  // scan issue and exchange decision
  assign issue_now = (state_r == S_SCAN) && (issue_r < m_r);
  assign do_swap   = (state_r == S_DECIDE) && found_r && (wv_r < bv_r) &&
                     (32'(swaps_r) < 32'(MAX_POPULATION + 1));

  // a new result word is produced
  assign out_set = (accept && cmd != CMD_RUN) || ((state_r == S_DECIDE) && !do_swap);

  // table port steering
  always_comb begin
    rd_re   = 1'b0;
    rd_addr = IDX_W'(in_ch.slot);
    if (issue_now) begin
      rd_re   = 1'b1;
      rd_addr = issue_r[IDX_W-1:0];
    end else if (accept && cmd == CMD_READ && in_range) begin
      rd_re   = 1'b1;
    end

    cur_wr.we           = 1'b0;
    cur_wr.addr         = IDX_W'(in_ch.slot);
    cur_wr.data.fitness = fit_sat;
    cur_wr.data.tag     = in_ch.tag;
    off_wr              = cur_wr;
    if (do_swap) begin
      cur_wr.we           = 1'b1;
      cur_wr.addr         = wi_r;
      cur_wr.data.fitness = bv_r;
      cur_wr.data.tag     = btag_r;
      off_wr.we           = 1'b1;
      off_wr.addr         = bi_r;
      off_wr.data.fitness = wv_r;
      off_wr.data.tag     = wtag_r;
    end else if (accept && in_range) begin
      cur_wr.we = (cmd == CMD_LOAD_CUR);
      off_wr.we = (cmd == CMD_LOAD_OFF);
    end
  end

  epr_table u_cur (
    .clk   (clk),
    .wr    (cur_wr),
    .re    (rd_re),
    .raddr (rd_addr),
    .rdata (cur_q)
  );

  epr_table u_off (
    .clk   (clk),
    .wr    (off_wr),
    .re    (rd_re),
    .raddr (rd_addr),
    .rdata (off_q)
  );

  // control state, search registers and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pop_r       <= POP_W'(256);
      half_r      <= 1'b0;
      rvalid_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_rd_r    <= 1'b0;
    end else begin
      // configuration
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POP_SIZE:  pop_r  <= cfg_wdata[POP_W-1:0];
          CFG_HALF_MODE: half_r <= cfg_wdata[0];
          default: ;
        endcase
      end

      // result word handshake
      if (out_set) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      // read pipeline of the scan
      rvalid_r <= issue_now;
      if (issue_now) begin
        ridx_r  <= issue_r;
        issue_r <= issue_r + CNT_W'(1);
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_rd_r    <= (cmd == CMD_READ) && in_range;
            out_swaps_r <= '0;
            if (cmd == CMD_RUN) begin
              m_r     <= m_scan;
              issue_r <= '0;
              swaps_r <= '0;
              found_r <= 1'b0;
              state_r <= (m_scan == '0) ? S_DECIDE : S_SCAN;
            end
          end
        end

        S_SCAN: begin
          // running minimum of current, maximum of offspring, first wins ties
          if (rvalid_r) begin
            found_r <= 1'b1;
            if (!found_r || cur_q.fitness < wv_r) begin
              wi_r   <= ridx_r[IDX_W-1:0];
              wv_r   <= cur_q.fitness;
              wtag_r <= cur_q.tag;
            end
            if (!found_r || off_q.fitness > bv_r) begin
              bi_r   <= ridx_r[IDX_W-1:0];
              bv_r   <= off_q.fitness;
              btag_r <= off_q.tag;
            end
            if (ridx_r == m_r - CNT_W'(1)) begin
              state_r <= S_DECIDE;
            end
          end
        end

        S_DECIDE: begin
          if (do_swap) begin
            swaps_r <= swaps_r + SWP_W'(1);
            issue_r <= '0;
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end else begin
            out_rd_r    <= 1'b0;
            out_swaps_r <= CNT_OUT_W'(swaps_r);
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result word
  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_fitness = out_rd_r ? cur_q.fitness : '0;
  assign out_ch.out_tag     = out_rd_r ? cur_q.tag : '0;
  assign out_ch.swap_count  = out_swaps_r;

endmodule

### rtl/epr_checker.sv
// ----------------------------------------------------------------------------
// epr_checker
// Port-level checks of the elitist replacement block, bound to the top level.
// ----------------------------------------------------------------------------
`include "elitist_population_replacement_assert.svh"

module epr_checker import epr_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [1:0]           in_cmd,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [FIT_W-1:0]     out_fitness,
  input logic [TAG_W-1:0]     out_tag,
  input logic [CNT_OUT_W-1:0] out_swap_count
);

  // a run result never carries entry fields
  `EPR_ASSERT_IMP(a_run_word_clean, out_valid && out_swap_count != '0, out_fitness == '0 && out_tag == '0)

  // load and read words answer in the next cycle
  `EPR_ASSERT_NXT(a_fast_result, in_valid && in_ready && (in_cmd == CMD_LOAD_CUR || in_cmd == CMD_LOAD_OFF || in_cmd == CMD_READ), out_valid)

  // a run's result word is only set in the decision state, not at acceptance
  `EPR_ASSERT_NXT(a_run_latency, in_valid && in_ready && in_cmd == CMD_RUN, !out_valid)

  // a stalled result word holds
  `EPR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_fitness) && $stable(out_tag) && $stable(out_swap_count))

endmodule

bind elitist_population_replacement epr_checker u_epr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_cmd         (in_ch.cmd),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_fitness    (out_ch.out_fitness),
  .out_tag        (out_ch.out_tag),
  .out_swap_count (out_ch.swap_count)
);

### sim/elitist_population_replacement_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// elitist_population_replacement_test
// Self-checking bench for the elitist replacement block. Command words go in
// through bursts with random gaps while the result side stalls on its own
// pattern. A scoreboard keeps a copy of both tables and the registers, works
// out the result word of every accepted command and compares it field by
// field with what the block returns.
// ----------------------------------------------------------------------------
module elitist_population_replacement_test import epr_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 300000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PRESSURE_WORDS = 40;
  localparam int RANDOM_WORDS   = 1900;
  localparam int TAIL_CYCLES    = 20;

  // tables, registers and awaited result words of the block
  class replacement_tracker;
    typedef struct packed {
      logic [FIT_W-1:0]     fitness;
      logic [TAG_W-1:0]     tag;
      logic [CNT_OUT_W-1:0] swaps;
    } result_t;

    entry_t           cur_tab [MAX_POPULATION];
    entry_t           off_tab [MAX_POPULATION];
    logic [POP_W-1:0] pop_size;
    logic             half_scan;
    result_t          awaited [$];
    int               errors;
    int               run_count;
    int               exchange_total;
    int               read_count;

    function new();
      foreach (cur_tab[i]) begin
        cur_tab[i] = '0;
        off_tab[i] = '0;
      end
      pop_size       = POP_W'(MAX_POPULATION);
      half_scan      = 1'b0;
      errors         = 0;
      run_count      = 0;
      exchange_total = 0;
      read_count     = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
      if (idx == CFG_POP_SIZE) begin
        pop_size = value;
      end else if (idx == CFG_HALF_MODE) begin
        half_scan = value[0];
      end
    endfunction

    // repeated worst-current / best-offspring exchange, first index wins ties
    function int run_exchanges();
      int     scan;
      int     swaps;
      int     w_idx;
      int     b_idx;
      entry_t held;
      scan  = (pop_size > MAX_POPULATION) ? MAX_POPULATION : int'(pop_size);
      swaps = 0;
      if (half_scan) begin
        scan = scan / 2;
      end
      if (scan == 0) begin
        return 0;
      end
      for (int pass = 0; pass <= MAX_POPULATION; pass++) begin
        w_idx = 0;
        b_idx = 0;
        for (int i = 1; i < scan; i++) begin
          if (cur_tab[i].fitness < cur_tab[w_idx].fitness) w_idx = i;
          if (off_tab[i].fitness > off_tab[b_idx].fitness) b_idx = i;
        end
        if (!(cur_tab[w_idx].fitness < off_tab[b_idx].fitness)) break;
        held           = cur_tab[w_idx];
        cur_tab[w_idx] = off_tab[b_idx];
        off_tab[b_idx] = held;
        swaps++;
      end
      return swaps;
    endfunction

    function void note_word(logic [1:0] cmd, logic [SLOT_W-1:0] slot,
                            logic [FIT_W-1:0] fit, logic [TAG_W-1:0] tag);
      result_t r;
      entry_t  e;
      int      n;
      r         = '0;
      e.fitness = (fit > FITNESS_CEIL) ? FITNESS_CEIL : fit;
      e.tag     = tag;
      case (cmd_t'(cmd))
        CMD_LOAD_CUR: cur_tab[slot] = e;
        CMD_LOAD_OFF: off_tab[slot] = e;
        CMD_RUN: begin
          n = run_exchanges();
          r.swaps = CNT_OUT_W'(n);
          run_count++;
          exchange_total += n;
        end
        CMD_READ: begin
          r.fitness = cur_tab[slot].fitness;
          r.tag     = cur_tab[slot].tag;
          read_count++;
        end
      endcase
      awaited.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [FIT_W-1:0] fit, logic [TAG_W-1:0] tag,
                               logic [CNT_OUT_W-1:0] swaps);
      result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result word with nothing awaited, expected none actual %0d/%0d/%0d",
                 $time, fit, tag, swaps);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare_field("out_fitness", 32'(want.fitness), 32'(fit));
      compare_field("out_tag", 32'(want.tag), 32'(tag));
      compare_field("swap_count", 32'(want.swaps), 32'(swaps));
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  epr_in_if  in_ch ();
  epr_out_if out_ch ();

  elitist_population_replacement dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  replacement_tracker tracker = new();

  // slots loaded so far, so that no run or read touches an unwritten entry
  bit cur_loaded [MAX_POPULATION];
  bit off_loaded [MAX_POPULATION];
  int words_sent  = 0;
  int burst_left  = 0;
  bit steady      = 1'b0;
  bit hold_request = 1'b0;
  bit rx_holding  = 1'b0;
  int quiet_cycles = 0;
  int settings    = 0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // accepted words into the scoreboard, results out of it, and the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        tracker.note_word(in_ch.cmd, in_ch.slot, in_ch.fitness, in_ch.tag);
      end
      if (out_ch.valid && out_ch.ready) begin
        tracker.check_result(out_ch.out_fitness, out_ch.out_tag, out_ch.swap_count);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
        $display("FAIL elitist_population_replacement");
        $finish;
      end
    end
  end

  // result side: stretches of steady, random, periodic and heavy stalling,
  // plus one long hold-off on request
  initial begin : receiver
    int mode;
    int stretch;
    int tick;
    out_ch.ready = 1'b0;
    tick = 0;
    forever begin
      if (hold_request) begin
        out_ch.ready = 1'b0;
        rx_holding   = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_holding   = 1'b0;
        hold_request = 1'b0;
      end
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(4, 64);
      repeat (stretch) begin
        @(negedge clk);
        tick++;
        case (mode)
          0:       out_ch.ready = 1'b1;
          1:       out_ch.ready = 1'($urandom_range(0, 1));
          2:       out_ch.ready = (tick % 3) != 0;
          default: out_ch.ready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  function automatic logic [FIT_W-1:0] pick_fitness();
    case ($urandom_range(0, 5))
      0:       return FIT_W'($urandom_range(0, 7));
      1:       return FITNESS_CEIL - FIT_W'($urandom_range(0, 3));
      2:       return FIT_W'($urandom_range(int'(FITNESS_CEIL) + 1, (1 << FIT_W) - 1));
      default: return FIT_W'($urandom);
    endcase
  endfunction

  // mostly inside the slots in use, sometimes anywhere in the table
  function automatic logic [SLOT_W-1:0] pick_slot(int span);
    if ($urandom_range(0, 9) < 7) begin
      return SLOT_W'($urandom_range(0, span - 1));
    end
    return SLOT_W'($urandom);
  endfunction

  // one command word, called at a falling edge; ends a burst with a gap
  task automatic send_word(cmd_t cmd, logic [SLOT_W-1:0] slot,
                           logic [FIT_W-1:0] fit, logic [TAG_W-1:0] tag);
    in_ch.cmd     = cmd;
    in_ch.slot    = slot;
    in_ch.fitness = fit;
    in_ch.tag     = tag;
    in_ch.valid   = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    words_sent++;
    if (cmd == CMD_LOAD_CUR) cur_loaded[slot] = 1'b1;
    if (cmd == CMD_LOAD_OFF) off_loaded[slot] = 1'b1;
    if (!steady) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_ch.valid = 1'b0;
        repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 24 : 4)) @(negedge clk);
        burst_left = $urandom_range(0, 30);
      end
    end
  endtask

  // stop offering and wait for every awaited result word
  task automatic drain();
    in_ch.valid = 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    drain();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = CFG_DAT_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_register(idx, CFG_DAT_W'(value));
  endtask

  // one setting with a random mix of loads, runs and reads
  task automatic run_phase(int size, bit half, int count);
    int                span;
    int                scan;
    int                op;
    logic [SLOT_W-1:0] s;
    write_reg(CFG_POP_SIZE, size);
    write_reg(CFG_HALF_MODE, half);
    settings++;
    scan = (size > MAX_POPULATION) ? MAX_POPULATION : size;
    span = (scan == 0) ? 1 : scan;
    if (half) scan = scan / 2;
    repeat (count) begin
      op = $urandom_range(0, 99);
      if (op < 30) begin
        send_word(CMD_LOAD_CUR, pick_slot(span), pick_fitness(), TAG_W'($urandom));
      end else if (op < 60) begin
        send_word(CMD_LOAD_OFF, pick_slot(span), pick_fitness(), TAG_W'($urandom));
      end else if (op < 75) begin
        // every scanned slot of both tables must hold a loaded entry
        for (int i = 0; i < scan; i++) begin
          if (!cur_loaded[i]) begin
            send_word(CMD_LOAD_CUR, SLOT_W'(i), pick_fitness(), TAG_W'($urandom));
          end
          if (!off_loaded[i]) begin
            send_word(CMD_LOAD_OFF, SLOT_W'(i), pick_fitness(), TAG_W'($urandom));
          end
        end
        send_word(CMD_RUN, SLOT_W'($urandom), FIT_W'($urandom), TAG_W'($urandom));
      end else if (op < 97) begin
        s = pick_slot(span);
        if (!cur_loaded[s]) begin
          send_word(CMD_LOAD_CUR, s, pick_fitness(), TAG_W'($urandom));
        end
        send_word(CMD_READ, s, FIT_W'($urandom), TAG_W'($urandom));
      end else begin
        drain();
      end
    end
  endtask

  initial begin : stimulus
    int phase;
    int size;
    int pick;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.cmd     = '0;
    in_ch.slot    = '0;
    in_ch.fitness = '0;
    in_ch.tag     = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed: saturation, ties, strict comparison, last slot, empty scans
    burst_left = $urandom_range(0, 8);
    write_reg(CFG_POP_SIZE, 4);
    write_reg(CFG_HALF_MODE, 0);
    settings++;
    send_word(CMD_LOAD_CUR, 0, '0, '1);
    send_word(CMD_LOAD_CUR, 1, '1, '0);
    send_word(CMD_LOAD_CUR, 2, FITNESS_CEIL + 1'b1, 16'h0001);
    send_word(CMD_LOAD_CUR, 3, 5, 16'h0002);
    send_word(CMD_LOAD_OFF, 0, 5, 16'h0010);
    send_word(CMD_LOAD_OFF, 1, FITNESS_CEIL, '1);
    send_word(CMD_LOAD_OFF, 2, 5, 16'h0012);
    send_word(CMD_LOAD_OFF, 3, 0, 16'h0013);
    send_word(CMD_READ, 1, '1, '1);
    send_word(CMD_RUN, '1, '1, '1);
    send_word(CMD_READ, 0, '0, '0);
    send_word(CMD_READ, 3, '0, '0);
    send_word(CMD_RUN, '0, '0, '0);
    send_word(CMD_LOAD_CUR, '1, 7, 16'habcd);
    send_word(CMD_READ, '1, '0, '0);
    send_word(CMD_LOAD_OFF, '1, FITNESS_CEIL, 16'h5a5a);
    // size zero and half of one scan nothing
    write_reg(CFG_POP_SIZE, 0);
    send_word(CMD_RUN, '0, '0, '0);
    write_reg(CFG_POP_SIZE, 1);
    write_reg(CFG_HALF_MODE, 1);
    send_word(CMD_RUN, '0, '0, '0);
    write_reg(CFG_POP_SIZE, 3);
    send_word(CMD_RUN, '0, '0, '0);
    write_reg(CFG_HALF_MODE, 0);
    write_reg(CFG_POP_SIZE, 1);
    send_word(CMD_RUN, '0, '0, '0);
    send_word(CMD_READ, 0, '0, '0);
    settings += 4;

    // random phases, mostly small populations, a few at full size
    phase = 0;
    while (words_sent < RANDOM_WORDS) begin
      phase++;
      steady     = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(0, 20);
      case (phase)
        4:  run_phase((1 << POP_W) - 1, 1'b0, 12);
        14: run_phase(MAX_POPULATION, 1'b1, 12);
        24: run_phase(MAX_POPULATION + $urandom_range(1, 255), 1'($urandom_range(0, 1)), 12);
        9: begin
          // long result hold-off while the input keeps offering words
          drain();
          hold_request = 1'b1;
          wait (rx_holding);
          steady = 1'b1;
          repeat (PRESSURE_WORDS) begin
            send_word(($urandom_range(0, 1) != 0) ? CMD_LOAD_CUR : CMD_LOAD_OFF,
                      SLOT_W'($urandom), pick_fitness(), TAG_W'($urandom));
          end
          drain();
        end
        default: begin
          pick = $urandom_range(0, 9);
          case (pick)
            0:       size = 0;
            1:       size = 1;
            2:       size = 2;
            8:       size = $urandom_range(17, 64);
            9:       size = $urandom_range(65, 128);
            default: size = $urandom_range(3, 16);
          endcase
          run_phase(size, 1'($urandom_range(0, 1)), $urandom_range(20, 60));
        end
      endcase
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("covered %0d command words over %0d settings, incl. sizes 0 to 511 and half scan",
             words_sent, settings);
    $display("%0d runs made %0d exchanges, %0d reads returned entries",
             tracker.run_count, tracker.exchange_total, tracker.read_count);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("PASS elitist_population_replacement");
    end else begin
      $display("FAIL elitist_population_replacement");
    end
    $finish;
  end

endmodule
